@@ src/swsr_pkg.sv @@
// Shared types and constants of the single-wire sensor reader.
package swsr_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_START_LOW    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT      = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ONE_THRESH   = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_INTERVAL = 8'd3;

    localparam logic [15:0] START_LOW_RST    = 16'd18000;
    localparam logic [7:0]  TIMEOUT_RST      = 8'd90;
    localparam logic [7:0]  ONE_THRESH_RST   = 8'd30;
    localparam logic [23:0] MIN_INTERVAL_RST = 24'd2000000;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_TIMEOUT  = 2'd1;
    localparam logic [1:0] ERR_CHECKSUM = 2'd2;

    // Phase counter runs from the response low/high preamble through the data bits.
    localparam logic [6:0] FIRST_DATA_PHASE = 7'd3;
    localparam logic [6:0] HUMIDITY_PHASE   = 7'd34;
    localparam logic [6:0] TEMP_PHASE       = 7'd66;
    localparam logic [6:0] LAST_PHASE       = 7'd82;

    localparam logic [15:0] TICKS_MAX = 16'hFFFF;
    localparam logic [23:0] TSR_MAX   = 24'hFFFFFF;

    typedef struct packed {
        logic [15:0] start_low_us;
        logic [7:0]  timeout_us;
        logic [7:0]  one_threshold_us;
        logic [23:0] min_interval_us;
    } swsr_cfg_t;

    typedef struct packed {
        logic       drive_low;
        logic       done_res;
        logic [1:0] error_code;
        logic [7:0] humidity_int;
        logic [7:0] humidity_frac;
        logic [7:0] temperature_int;
        logic [7:0] temperature_frac;
        logic [7:0] checksum_byte;
        logic       sum_match;
    } swsr_result_t;

endpackage

@@ src/swsr_if.sv @@
// Channel interfaces: line samples, results and register writes.
interface swsr_sample_if;
    logic valid;
    logic ready;
    logic start_request;
    logic line_level;

    modport source (output valid, output start_request, output line_level, input ready);
    modport sink   (input valid, input start_request, input line_level, output ready);
endinterface

interface swsr_result_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       done_res;
    logic [1:0] error_code;
    logic [7:0] humidity_int;
    logic [7:0] humidity_frac;
    logic [7:0] temperature_int;
    logic [7:0] temperature_frac;
    logic [7:0] checksum_byte;
    logic       sum_match;

    modport source (output valid, output drive_low, output done_res, output error_code,
                    output humidity_int, output humidity_frac, output temperature_int,
                    output temperature_frac, output checksum_byte, output sum_match,
                    input ready);
    modport sink   (input valid, input drive_low, input done_res, input error_code,
                    input humidity_int, input humidity_frac, input temperature_int,
                    input temperature_frac, input checksum_byte, input sum_match,
                    output ready);
endinterface

interface swsr_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [swsr_pkg::CFG_INDEX_W-1:0]   index;
    logic [swsr_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/single_wire_sensor_reader.sv @@
// Single-wire humidity/temperature sensor reader, top level.
//
// sample: one item per microsecond tick, carrying start_request and the
//   sampled level of the data line. result: one item for every sample item,
//   carrying drive_low (pull the line low while set), done_res, error_code
//   and, in the tick a read completes, the data bytes and checksum status.
// cfg: register writes (start low time, phase timeout, one threshold,
//   minimum interval between reads); always ready, effective at once.
// A sample item is held in the input register and stepped through the engine when
//   the result register can advance, which loads its result item into the result
//   register. Throughput: one item per cycle while result.ready is not holding the
//   flow; the whole per-tick step is a single pass through the engine logic.
// A stalled result item holds in the result register while the next sample
//   item waits in the input register; sample.ready drops only when both are
//   full and result.ready is low.
// Reset: configuration returns to its defaults, the engine goes idle and the
//   time since the last read restarts from zero, so the first request is
//   refused until the minimum interval has passed.
module single_wire_sensor_reader (
    input  logic            clk,
    input  logic            rst_n,
    swsr_sample_if.sink     sample,
    swsr_result_if.source   result,
    swsr_cfg_if.sink        cfg
);

    swsr_pkg::swsr_cfg_t    cfg_val;
    swsr_pkg::swsr_result_t result_next;
    swsr_pkg::swsr_result_t out_data_reg;
    logic                   out_valid_reg;
    logic                   in_valid_reg;
    logic                   in_start_reg;
    logic                   in_line_reg;
    logic                   advance;
    logic                   fire;

    assign advance      = !out_valid_reg || result.ready;
    assign fire         = in_valid_reg && advance;
    assign sample.ready = !in_valid_reg || advance;

    swsr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_val (cfg_val)
    );

    swsr_engine u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_val       (cfg_val),
        .fire          (fire),
        .start_request (in_start_reg),
        .line_level    (in_line_reg),
        .result_next   (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample.ready)
            begin
                in_valid_reg <= sample.valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            in_start_reg <= sample.start_request;
            in_line_reg  <= sample.line_level;
        end
        if (fire)
        begin
            out_data_reg <= result_next;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.drive_low        = out_data_reg.drive_low;
    assign result.done_res         = out_data_reg.done_res;
    assign result.error_code       = out_data_reg.error_code;
    assign result.humidity_int     = out_data_reg.humidity_int;
    assign result.humidity_frac    = out_data_reg.humidity_frac;
    assign result.temperature_int  = out_data_reg.temperature_int;
    assign result.temperature_frac = out_data_reg.temperature_frac;
    assign result.checksum_byte    = out_data_reg.checksum_byte;
    assign result.sum_match        = out_data_reg.sum_match;

endmodule

@@ src/swsr_cfg.sv @@
// Configuration register file of the sensor reader.
module swsr_cfg (
    input  logic                 clk,
    input  logic                 rst_n,
    swsr_cfg_if.sink             cfg,
    output swsr_pkg::swsr_cfg_t  cfg_val
);

    swsr_pkg::swsr_cfg_t cfg_reg;

    assign cfg.ready = 1'b1;
    assign cfg_val   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_low_us     <= swsr_pkg::START_LOW_RST;
            cfg_reg.timeout_us       <= swsr_pkg::TIMEOUT_RST;
            cfg_reg.one_threshold_us <= swsr_pkg::ONE_THRESH_RST;
            cfg_reg.min_interval_us  <= swsr_pkg::MIN_INTERVAL_RST;
        end
        else if (cfg.valid)
        begin
            // unknown indexes drop silently
            case (cfg.index)
                swsr_pkg::CFG_START_LOW:    cfg_reg.start_low_us     <= cfg.data[15:0];
                swsr_pkg::CFG_TIMEOUT:      cfg_reg.timeout_us       <= cfg.data[7:0];
                swsr_pkg::CFG_ONE_THRESH:   cfg_reg.one_threshold_us <= cfg.data[7:0];
                swsr_pkg::CFG_MIN_INTERVAL: cfg_reg.min_interval_us  <= cfg.data;
                default:                    cfg_reg                  <= cfg_reg;
            endcase
        end
    end

endmodule

@@ src/swsr_engine.sv @@
// Per-tick protocol engine: read state and the result of one line sample.
module swsr_engine (
    input  logic                    clk,
    input  logic                    rst_n,
    input  swsr_pkg::swsr_cfg_t     cfg_val,
    input  logic                    fire,
    input  logic                    start_request,
    input  logic                    line_level,
    output swsr_pkg::swsr_result_t  result_next
);

    logic [1:0]  mode_reg, mode_next, mode_cur;
    logic [6:0]  phase_index_reg, phase_index_next;
    logic [15:0] phase_ticks_reg, phase_ticks_next;
    logic [15:0] bit_shifter_reg, bit_shifter_next;
    logic [15:0] humidity_word_reg, humidity_word_next;
    logic [15:0] temperature_word_reg, temperature_word_next;
    logic [23:0] time_since_read_reg, time_since_read_next;
    logic        expect_level;
    logic        cleared;
    logic [15:0] shifted;
    logic [7:0]  byte_sum;

    always_comb
    begin
        mode_next             = mode_reg;
        phase_index_next      = phase_index_reg;
        phase_ticks_next      = phase_ticks_reg;
        bit_shifter_next      = bit_shifter_reg;
        humidity_word_next    = humidity_word_reg;
        temperature_word_next = temperature_word_reg;
        result_next           = '0;
        cleared               = 1'b0;
        expect_level          = ~phase_index_reg[0];
        shifted               = bit_shifter_reg;
        byte_sum              = humidity_word_reg[15:8] + humidity_word_reg[7:0]
                              + temperature_word_reg[15:8] + temperature_word_reg[7:0];

        case (mode_reg)
            swsr_pkg::MODE_START: mode_cur = swsr_pkg::MODE_START;
            swsr_pkg::MODE_READ:  mode_cur = swsr_pkg::MODE_READ;
            default:              mode_cur = swsr_pkg::MODE_IDLE;
        endcase
        mode_next = mode_cur;

        if (mode_cur == swsr_pkg::MODE_IDLE && start_request)
        begin
            if (time_since_read_reg >= cfg_val.min_interval_us)
            begin
                mode_next        = swsr_pkg::MODE_START;
                phase_ticks_next = '0;
            end
            else
            begin
                result_next.done_res   = 1'b1;
                result_next.error_code = swsr_pkg::ERR_TIMEOUT;
            end
        end

        if (mode_next == swsr_pkg::MODE_START)
        begin
            if (phase_ticks_next >= cfg_val.start_low_us)
            begin
                mode_next        = swsr_pkg::MODE_READ;
                phase_index_next = '0;
                phase_ticks_next = '0;
                bit_shifter_next = '0;
            end
            else
            begin
                result_next.drive_low = 1'b1;
                phase_ticks_next      = phase_ticks_next + 16'd1;
            end
        end
        else if (mode_cur == swsr_pkg::MODE_READ)
        begin
            if (phase_ticks_reg > {8'd0, cfg_val.timeout_us})
            begin
                mode_next              = swsr_pkg::MODE_IDLE;
                result_next.done_res   = 1'b1;
                result_next.error_code = swsr_pkg::ERR_TIMEOUT;
            end
            else if (line_level == expect_level)
            begin
                if (phase_ticks_reg != swsr_pkg::TICKS_MAX)
                begin
                    phase_ticks_next = phase_ticks_reg + 16'd1;
                end
            end
            else
            begin
                // shift a data bit at the end of each data-bit high pulse
                if (phase_index_reg >= swsr_pkg::FIRST_DATA_PHASE && expect_level)
                begin
                    shifted = {bit_shifter_reg[14:0],
                               (phase_ticks_reg > {8'd0, cfg_val.one_threshold_us})};
                end
                bit_shifter_next = shifted;
                if (phase_index_reg == swsr_pkg::HUMIDITY_PHASE)
                begin
                    humidity_word_next = shifted;
                end
                else if (phase_index_reg == swsr_pkg::TEMP_PHASE)
                begin
                    temperature_word_next = shifted;
                end

                if (phase_index_reg >= swsr_pkg::LAST_PHASE)
                begin
                    mode_next                    = swsr_pkg::MODE_IDLE;
                    bit_shifter_next             = '0;
                    cleared                      = 1'b1;
                    result_next.done_res         = 1'b1;
                    result_next.checksum_byte    = shifted[7:0];
                    result_next.humidity_int     = humidity_word_reg[15:8];
                    result_next.humidity_frac    = humidity_word_reg[7:0];
                    result_next.temperature_int  = temperature_word_reg[15:8];
                    result_next.temperature_frac = temperature_word_reg[7:0];
                    result_next.sum_match        = (byte_sum == shifted[7:0]);
                    result_next.error_code       = (byte_sum == shifted[7:0]) ?
                                                   swsr_pkg::ERR_OK : swsr_pkg::ERR_CHECKSUM;
                end
                else
                begin
                    phase_index_next = phase_index_reg + 7'd1;
                    phase_ticks_next = 16'd1;
                end
            end
        end

        if (cleared)
        begin
            time_since_read_next = '0;
        end
        else if (time_since_read_reg != swsr_pkg::TSR_MAX)
        begin
            time_since_read_next = time_since_read_reg + 24'd1;
        end
        else
        begin
            time_since_read_next = time_since_read_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg             <= swsr_pkg::MODE_IDLE;
            phase_index_reg      <= '0;
            phase_ticks_reg      <= '0;
            bit_shifter_reg      <= '0;
            humidity_word_reg    <= '0;
            temperature_word_reg <= '0;
            time_since_read_reg  <= '0;
        end
        else if (fire)
        begin
            mode_reg             <= mode_next;
            phase_index_reg      <= phase_index_next;
            phase_ticks_reg      <= phase_ticks_next;
            bit_shifter_reg      <= bit_shifter_next;
            humidity_word_reg    <= humidity_word_next;
            temperature_word_reg <= temperature_word_next;
            time_since_read_reg  <= time_since_read_next;
        end
    end

endmodule

@@ src/swsr_checker.sv @@
// Port-level checks of the sensor reader, bound to its top level.
module swsr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic       drive_low,
    input logic       done_res,
    input logic [1:0] error_code,
    input logic [7:0] humidity_int,
    input logic [7:0] checksum_byte,
    input logic       sum_match
);

    // hold a stalled result item
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(error_code)
            && $stable(done_res) && $stable(checksum_byte) && $stable(drive_low))
    else $error("stalled result item changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !done_res |-> error_code == swsr_pkg::ERR_OK && !sum_match
            && checksum_byte == 8'd0 && humidity_int == 8'd0)
    else $error("status or data outside a done tick");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(drive_low && done_res))
    else $error("line driven in a done tick");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && done_res |-> (sum_match == (error_code == swsr_pkg::ERR_OK))
            && error_code != 2'd3)
    else $error("checksum flag disagrees with error code");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && done_res && error_code == swsr_pkg::ERR_TIMEOUT
            |-> humidity_int == 8'd0 && checksum_byte == 8'd0)
    else $error("data bytes set on a timed-out read");

endmodule

bind single_wire_sensor_reader swsr_checker u_swsr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .drive_low     (result.drive_low),
    .done_res      (result.done_res),
    .error_code    (result.error_code),
    .humidity_int  (result.humidity_int),
    .checksum_byte (result.checksum_byte),
    .sum_match     (result.sum_match)
);

@@ bench/single_wire_sensor_reader_test.sv @@
// Self-checking bench for the single-wire sensor reader: line waveforms in, readings checked.
module single_wire_sensor_reader_test;

    localparam int PIPE_CYCLES  = 6;
    localparam int SETTLE_LIMIT = 100000;
    localparam int SHOW_MAX     = 10;
    localparam logic [swsr_pkg::CFG_INDEX_W-1:0] CFG_FIRST_UNUSED =
        swsr_pkg::CFG_MIN_INTERVAL + 8'd1;

    typedef struct packed {
        logic req;
        logic line;
    } line_sample_t;

    logic clk = 1'b0;
    logic rst_n;

    swsr_sample_if smp ();
    swsr_result_if res ();
    swsr_cfg_if    cfg_ch ();

    single_wire_sensor_reader dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (smp),
        .result (res),
        .cfg    (cfg_ch)
    );

    always #2 clk = ~clk;

    line_sample_t           line_samples[$];
    swsr_pkg::swsr_result_t predicted_reports[$];
    line_sample_t           next_sample;
    swsr_pkg::swsr_result_t got, want;

    int samples_planned = 0;
    int samples_taken   = 0;
    int reports_checked = 0;
    int mismatches      = 0;
    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int clean_reads     = 0;
    int bad_sums        = 0;
    int failed_reads    = 0;
    int settings_used   = 0;

    // Sensor state as the bench sees it
    swsr_pkg::swsr_cfg_t cfg_now;
    logic [1:0]          rd_mode;
    logic [6:0]          phase_idx;
    logic [15:0]         phase_cnt;
    logic [15:0]         shifter;
    logic [15:0]         hum_word;
    logic [15:0]         temp_word;
    logic [23:0]         since_read;

    function automatic swsr_pkg::swsr_result_t sense_tick(logic req, logic line);
        swsr_pkg::swsr_result_t r;
        logic                   want_lvl;
        logic                   cleared;
        logic [7:0]             sum;
        r = '0;
        cleared = 1'b0;
        if (rd_mode != swsr_pkg::MODE_START && rd_mode != swsr_pkg::MODE_READ)
        begin
            rd_mode = swsr_pkg::MODE_IDLE;
            if (req)
            begin
                if (since_read >= cfg_now.min_interval_us)
                begin
                    rd_mode = swsr_pkg::MODE_START;
                    phase_cnt = '0;
                end
                else
                begin
                    r.done_res = 1'b1;
                    r.error_code = swsr_pkg::ERR_TIMEOUT;
                end
            end
        end
        if (rd_mode == swsr_pkg::MODE_START)
        begin
            if (phase_cnt >= cfg_now.start_low_us)
            begin
                rd_mode = swsr_pkg::MODE_READ;
                phase_idx = '0;
                phase_cnt = '0;
                shifter = '0;
            end
            else
            begin
                r.drive_low = 1'b1;
                phase_cnt = phase_cnt + 16'd1;
            end
        end
        else if (rd_mode == swsr_pkg::MODE_READ)
        begin
            want_lvl = ~phase_idx[0];
            if (phase_cnt > {8'd0, cfg_now.timeout_us})
            begin
                rd_mode = swsr_pkg::MODE_IDLE;
                r.done_res = 1'b1;
                r.error_code = swsr_pkg::ERR_TIMEOUT;
            end
            else if (line == want_lvl)
            begin
                if (phase_cnt != swsr_pkg::TICKS_MAX)
                    phase_cnt = phase_cnt + 16'd1;
            end
            else
            begin
                // a phase closes here: a data-bit high pulse shifts in its bit
                if (phase_idx >= swsr_pkg::FIRST_DATA_PHASE && want_lvl)
                    shifter = {shifter[14:0], phase_cnt > {8'd0, cfg_now.one_threshold_us}};
                if (phase_idx == swsr_pkg::HUMIDITY_PHASE)
                    hum_word = shifter;
                else if (phase_idx == swsr_pkg::TEMP_PHASE)
                    temp_word = shifter;
                if (phase_idx >= swsr_pkg::LAST_PHASE)
                begin
                    rd_mode = swsr_pkg::MODE_IDLE;
                    r.done_res = 1'b1;
                    r.checksum_byte = shifter[7:0];
                    shifter = '0;
                    r.humidity_int = hum_word[15:8];
                    r.humidity_frac = hum_word[7:0];
                    r.temperature_int = temp_word[15:8];
                    r.temperature_frac = temp_word[7:0];
                    sum = r.humidity_int + r.humidity_frac + r.temperature_int
                          + r.temperature_frac;
                    r.sum_match = (sum == r.checksum_byte);
                    r.error_code = r.sum_match ? swsr_pkg::ERR_OK : swsr_pkg::ERR_CHECKSUM;
                    cleared = 1'b1;
                end
                else
                begin
                    phase_idx = phase_idx + 7'd1;
                    phase_cnt = 16'd1;
                end
            end
        end
        if (cleared)
            since_read = '0;
        else if (since_read != swsr_pkg::TSR_MAX)
            since_read = since_read + 24'd1;
        if (r.done_res)
        begin
            if (r.error_code == swsr_pkg::ERR_OK)
                clean_reads++;
            else if (r.error_code == swsr_pkg::ERR_CHECKSUM)
                bad_sums++;
            else
                failed_reads++;
        end
        return r;
    endfunction

    function automatic string show(swsr_pkg::swsr_result_t r);
        return $sformatf("drive %b done %b err %0d hum %02h.%02h temp %02h.%02h sum %02h ok %b",
                         r.drive_low, r.done_res, r.error_code, r.humidity_int,
                         r.humidity_frac, r.temperature_int, r.temperature_frac,
                         r.checksum_byte, r.sum_match);
    endfunction

    // Sample driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            smp.valid <= 1'b0;
            smp.start_request <= 1'b0;
            smp.line_level <= 1'b0;
        end
        else
        begin
            if (smp.valid && smp.ready)
            begin
                predicted_reports.push_back(sense_tick(smp.start_request, smp.line_level));
                samples_taken++;
            end
            if (!smp.valid || smp.ready)
            begin
                if (line_samples.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_sample = line_samples.pop_front();
                    smp.valid <= 1'b1;
                    smp.start_request <= next_sample.req;
                    smp.line_level <= next_sample.line;
                end
                else
                    smp.valid <= 1'b0;
            end
        end
    end

    // Reading monitor
    always @(posedge clk)
    begin
        if (!rst_n)
            res.ready <= 1'b0;
        else
        begin
            if (res.valid && res.ready)
            begin
                got = '{res.drive_low, res.done_res, res.error_code, res.humidity_int,
                        res.humidity_frac, res.temperature_int, res.temperature_frac,
                        res.checksum_byte, res.sum_match};
                if (predicted_reports.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= SHOW_MAX)
                        $display("Reading with nothing predicted: %s", show(got));
                end
                else
                begin
                    want = predicted_reports.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= SHOW_MAX)
                            $display("Reading %0d differs\n  expected %s\n  actual   %s",
                                     reports_checked, show(want), show(got));
                    end
                end
                reports_checked++;
            end
            res.ready <= $urandom_range(99) >= recv_idle_pct;
        end
    end

    task automatic add_sample(logic req, logic line);
        line_samples.push_back('{req, line});
        samples_planned++;
    endtask

    // Hold until every sample is taken and every reading is in, then let the pipe empty
    task automatic settle();
        int guard;
        guard = 0;
        while ((samples_taken != samples_planned || predicted_reports.size() != 0)
               && guard < SETTLE_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (PIPE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [swsr_pkg::CFG_INDEX_W-1:0] idx,
                             logic [swsr_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            swsr_pkg::CFG_START_LOW:    cfg_now.start_low_us = val[15:0];
            swsr_pkg::CFG_TIMEOUT:      cfg_now.timeout_us = val[7:0];
            swsr_pkg::CFG_ONE_THRESH:   cfg_now.one_threshold_us = val[7:0];
            swsr_pkg::CFG_MIN_INTERVAL: cfg_now.min_interval_us = val;
            default: ;
        endcase
    endtask

    task automatic apply_setting(logic [15:0] low_ticks, logic [7:0] tmo, logic [7:0] thr,
                                 logic [23:0] gap, int send_pct, int recv_pct);
        settle();
        // junk above each register's width must be dropped
        write_reg(swsr_pkg::CFG_START_LOW, {8'($urandom()), low_ticks});
        write_reg(swsr_pkg::CFG_TIMEOUT, {16'($urandom()), tmo});
        write_reg(swsr_pkg::CFG_ONE_THRESH, {16'($urandom()), thr});
        write_reg(swsr_pkg::CFG_MIN_INTERVAL, gap);
        write_reg(8'($urandom_range(CFG_FIRST_UNUSED, 2 ** swsr_pkg::CFG_INDEX_W - 1)),
                  24'($urandom()));
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        settings_used++;
    endtask

    // One sensor exchange: request, start pulse, preamble and 40 bits
    task automatic plan_read(bit broken);
        logic [7:0]  b0, b1, b2, b3, sum;
        logic [39:0] frame;
        logic        lvl;
        int          tmo, thr, wait_ticks, len, cut, hi;
        tmo = int'(cfg_now.timeout_us);
        thr = int'(cfg_now.one_threshold_us);
        wait_ticks = cfg_now.min_interval_us > 64 ? 64 : int'(cfg_now.min_interval_us);
        // come early now and then so the request is refused
        if ($urandom_range(7) == 0)
            wait_ticks = int'($urandom_range(0, wait_ticks));
        else
            wait_ticks += int'($urandom_range(0, 4));
        repeat (wait_ticks) add_sample(1'b0, 1'($urandom_range(1)));
        add_sample(1'b1, 1'($urandom_range(1)));
        repeat (cfg_now.start_low_us > 16 ? 16 : int'(cfg_now.start_low_us))
            add_sample(1'b0, 1'($urandom_range(1)));
        case ($urandom_range(3))
            0:       {b0, b1, b2, b3} = '0;
            1:       {b0, b1, b2, b3} = '1;
            default: {b0, b1, b2, b3} = $urandom();
        endcase
        sum = b0 + b1 + b2 + b3;
        if ($urandom_range(3) == 0)
            sum = 8'($urandom());
        frame = {b0, b1, b2, b3, sum};
        cut = broken ? int'($urandom_range(0, swsr_pkg::LAST_PHASE))
                     : int'(swsr_pkg::LAST_PHASE) + 1;
        for (int ph = 0; ph <= int'(swsr_pkg::LAST_PHASE); ph++)
        begin
            lvl = ~ph[0];
            if (ph == cut)
            begin
                // hold the level past the timeout, then one more sample
                repeat (tmo + 1 + $urandom_range(0, 1)) add_sample(1'b0, lvl);
                add_sample(1'b0, 1'($urandom_range(1)));
                return;
            end
            if (ph >= int'(swsr_pkg::FIRST_DATA_PHASE) && lvl && frame[39 - (ph - 4) / 2]
                && thr < tmo)
                len = thr + 1 + ((thr + 2 <= tmo && $urandom_range(1) == 1) ? 1 : 0);
            else
            begin
                hi = (ph >= int'(swsr_pkg::FIRST_DATA_PHASE) && lvl && thr < tmo) ? thr : tmo;
                len = (hi <= 8 && $urandom_range(3) == 0) ? hi
                                                          : int'($urandom_range(1, hi < 2 ? hi : 2));
            end
            repeat (len) add_sample($urandom_range(7) == 0, lvl);
        end
        // falling edge that closes the last bit
        add_sample(1'b0, 1'b0);
    endtask

    // Plan exactly budget samples; the tail of the last exchange is dropped
    task automatic plan_traffic(int budget);
        int stop_at;
        stop_at = samples_planned + budget;
        while (samples_planned < stop_at)
        begin
            case ($urandom_range(19))
                0, 1, 2: repeat ($urandom_range(5, 30))
                             add_sample($urandom_range(3) == 0, 1'($urandom_range(1)));
                3, 4, 5: plan_read(1'b1);
                default: plan_read(1'b0);
            endcase
        end
        while (samples_planned > stop_at)
        begin
            void'(line_samples.pop_back());
            samples_planned--;
        end
    endtask

    task automatic run_traffic(int budget);
        plan_traffic(budget / 2);
        // pause the sender until every reading is back
        settle();
        plan_traffic(budget - budget / 2);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        cfg_now = '{swsr_pkg::START_LOW_RST, swsr_pkg::TIMEOUT_RST, swsr_pkg::ONE_THRESH_RST,
                    swsr_pkg::MIN_INTERVAL_RST};
        rd_mode = swsr_pkg::MODE_IDLE;
        phase_idx = '0;
        phase_cnt = '0;
        shifter = '0;
        hum_word = '0;
        temp_word = '0;
        since_read = '0;
        send_idle_pct = 22;
        recv_idle_pct = 65;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // defaults: the interval since reset has not passed, so requests are refused
        add_sample(1'b1, 1'b0);
        add_sample(1'b0, 1'b1);
        add_sample(1'b1, 1'b1);
        add_sample(1'b0, 1'b0);

        apply_setting(16'd0, 8'd4, 8'd1, 24'd0, 22, 65);
        add_sample(1'b1, 1'b0);            // accepted with no start pulse
        add_sample(1'b0, 1'b0);            // preamble high ends at once
        add_sample(1'b0, 1'b0);
        add_sample(1'b1, 1'b0);            // request while busy
        repeat (3) add_sample(1'b0, 1'b0); // low phase runs past the timeout
        add_sample(1'b1, 1'b1);            // fresh request straight after
        repeat (6) add_sample(1'b0, 1'b1);
        plan_traffic(190);

        apply_setting(16'd3, 8'd6, 8'd2, 24'd20, 22, 65);
        plan_traffic(260);
        apply_setting(16'd1, 8'd255, 8'd255, 24'd0, 65, 22);
        plan_traffic(100);
        apply_setting(16'd2, 8'd1, 8'd1, 24'd3, 65, 22);
        run_traffic(200);
        apply_setting(16'hFFFF, 8'd90, 8'd30, swsr_pkg::TSR_MAX, 0, 0);
        plan_traffic(50);
        apply_setting(16'd1, 8'd7, 8'd4, 24'd8, 0, 0);
        plan_traffic(230);
        settle();

        $display("Covered %0d line samples under %0d register settings, %0d readings checked.",
                 samples_taken, settings_used, reports_checked);
        $display("Reads seen: %0d clean, %0d bad checksum, %0d timed out or refused.",
                 clean_reads, bad_sums, failed_reads);
        if (mismatches == 0 && predicted_reports.size() == 0
            && samples_taken == samples_planned)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #1600000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
